>>> hdl/vrbprb_pkg.sv
// ----------------------------------------------------------------------------
// VRB to PRB interleaver package
// Shared widths, register indexes, mapping modes and the bundle geometry type.
// ----------------------------------------------------------------------------
package vrbprb_pkg;

  localparam int unsigned MaxBlocksDef = 275;

  localparam int unsigned VrbW   = 9;
  localparam int unsigned PrbW   = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 9;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAP_MODE      = 3'd0,
    CFG_CSET_BASE     = 3'd1,
    CFG_BWP_START     = 3'd2,
    CFG_BWP_LEN       = 3'd3,
    CFG_BUNDLE_LOG2   = 3'd4,
    CFG_LIST_LENGTH   = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_NONIL_COMMON = 3'd0,
    MODE_NONIL_OTHER  = 3'd1,
    MODE_IL_CORESET0  = 3'd2,
    MODE_IL_COMMON    = 3'd3,
    MODE_IL_OTHER     = 3'd4
  } map_mode_e;

  // Bundle geometry derived from the configuration registers.
  typedef struct packed {
    logic       interleaved;
    logic [8:0] offset;
    logic [1:0] lg;      // log2 of the bundle size
    logic [3:0] first;   // size of the first bundle
    logic [3:0] last;    // size of the last bundle
    logic [9:0] cols;    // half the bundle count
  } geom_t;

endpackage

>>> hdl/vrb_to_prb_interleaver_core.sv
// ----------------------------------------------------------------------------
// VRB to PRB interleaver core
// Maps one virtual resource block index to a physical resource block index.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i, in_stall_o, vrb_index_i) carries one VRB
// index per request. The output channel (out_valid_o, out_stall_i) returns
// prb_index_o and out_of_range_o, one result for each request, in order.
// An input register feeds the mapping logic and a result register holds the
// answer; each request passes through the input register and then the
// result register before out_valid_o rises. While in_stall_o is low a new
// request is accepted in every cycle: one index per clock sustained.
// Bundle geometry is recomputed into a register in the cycle after a write;
// the user makes writes only while the block is empty; it is not enforced.
// When the receiver stalls, the result register holds its value and the input
// register still takes one more request; in_stall_o rises only when both are
// full and the receiver stalls. Reset empties both registers and loads the
// configuration defaults: non-interleaved other mode, BWP size and list
// length 275.
// ----------------------------------------------------------------------------
module vrb_to_prb_interleaver_core #(
  parameter int unsigned MAX_BLOCKS = vrbprb_pkg::MaxBlocksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vrbprb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vrbprb_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vrbprb_pkg::VrbW-1:0]     vrb_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vrbprb_pkg::PrbW-1:0]     prb_index_o,
  output logic                          out_of_range_o
);
  import vrbprb_pkg::*;

  localparam logic [9:0] MaxLen = 10'(MAX_BLOCKS);

  // Configuration registers.
  logic [2:0] map_mode_q;
  logic [8:0] cset_base_q;
  logic [8:0] bwp_start_q;
  logic [8:0] bwp_len_q;
  logic [1:0] bundle_log2_q;
  logic [8:0] list_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_mode_q      <= MODE_NONIL_OTHER;
      cset_base_q     <= '0;
      bwp_start_q     <= '0;
      bwp_len_q       <= 9'd275;
      bundle_log2_q   <= 2'd1;
      list_length_q   <= 9'd275;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAP_MODE:      map_mode_q      <= cfg_wdata_i[2:0];
        CFG_CSET_BASE:     cset_base_q     <= cfg_wdata_i;
        CFG_BWP_START:     bwp_start_q     <= cfg_wdata_i;
        CFG_BWP_LEN:       bwp_len_q       <= cfg_wdata_i;
        CFG_BUNDLE_LOG2:   bundle_log2_q   <= cfg_wdata_i[1:0];
        CFG_LIST_LENGTH:   list_length_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Bundle geometry.
  geom_t       geom_d, geom_q;
  logic [10:0] tot3;
  logic [9:0]  tot4;
  logic [3:0]  l4, mask4, rem4;
  logic [10:0] nb3, nb4;
  logic [9:0]  nb2;

  always_comb begin
    tot3  = 11'(bwp_len_q) + 11'(cset_base_q) + 11'(bwp_start_q);
    tot4  = 10'(bwp_len_q) + 10'(bwp_start_q);
    l4    = 4'(4'd1 << bundle_log2_q);
    mask4 = l4 - 4'd1;
    rem4  = tot4[3:0] & mask4;
    nb2   = (10'(bwp_len_q) + 10'd1) >> 1;
    nb3   = (tot3 + 11'd1) >> 1;
    nb4   = (11'(tot4) + 11'(mask4)) >> bundle_log2_q;

    geom_d             = '0;
    geom_d.lg          = 2'd1;
    geom_d.interleaved = 1'b1;
    unique case (map_mode_e'(map_mode_q))
      MODE_NONIL_COMMON: begin
        geom_d.offset      = cset_base_q;
        geom_d.interleaved = 1'b0;
      end
      MODE_IL_CORESET0: begin
        geom_d.offset = cset_base_q;
        geom_d.first  = 4'd2;
        geom_d.last   = bwp_len_q[0] ? 4'd1 : 4'd2;
        geom_d.cols   = nb2 >> 1;
      end
      MODE_IL_COMMON: begin
        geom_d.offset = cset_base_q;
        geom_d.first  = (bwp_start_q[0] ^ cset_base_q[0]) ? 4'd1 : 4'd2;
        geom_d.last   = tot3[0] ? 4'd1 : 4'd2;
        geom_d.cols   = 10'(nb3 >> 1);
      end
      MODE_IL_OTHER: begin
        geom_d.lg    = bundle_log2_q;
        geom_d.first = l4 - (bwp_start_q[3:0] & mask4);
        geom_d.last  = (rem4 != 4'd0) ? rem4 : l4;
        geom_d.cols  = 10'(nb4 >> 1);
      end
      default: begin
        geom_d.interleaved = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    geom_q <= geom_d;
  end

  // Pipeline control.
  logic            s1_valid_q, s2_valid_q;
  logic [VrbW-1:0] s1_vrb_q;
  logic            adv2, adv1;

  assign adv2       = !s2_valid_q || !out_stall_i;
  assign adv1       = !s1_valid_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv1) begin
      s1_vrb_q <= vrb_index_i;
    end
  end

  // Mapping of the registered index.
  logic [9:0]      len, f, scaled;
  logic [VrbW-1:0] d;
  logic [9:0]      j;
  logic [3:0]      k, lmask;
  logic            oor, in_place;
  logic [PrbW-1:0] prb_d, prb_q;
  logic            oor_q;

  always_comb begin
    len      = (10'(list_length_q) < MaxLen) ? 10'(list_length_q) : MaxLen;
    oor      = 10'(s1_vrb_q) >= len;
    in_place = !geom_q.interleaved || (s1_vrb_q < 9'(geom_q.first)) ||
               ((10'(s1_vrb_q) + 10'(geom_q.last)) >= len);
    lmask    = 4'(4'd1 << geom_q.lg) - 4'd1;
    d        = s1_vrb_q - 9'(geom_q.first);
    j        = 10'(d >> geom_q.lg) + 10'd1;
    k        = d[3:0] & lmask;
    // Two-row interleaver: bundle j = 2c + r goes to r * C + c.
    f        = (j[0] ? geom_q.cols : 10'd0) + (j >> 1);
    scaled   = (f - 10'd1) << geom_q.lg;
    if (oor) begin
      prb_d = '0;
    end else if (in_place) begin
      prb_d = 10'(s1_vrb_q) + 10'(geom_q.offset);
    end else begin
      prb_d = scaled + 10'(geom_q.first) + 10'(k) + 10'(geom_q.offset);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_valid_q) begin
      prb_q <= prb_d;
      oor_q <= oor;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign prb_index_o    = prb_q;
  assign out_of_range_o = oor_q;

endmodule

>>> hdl/vrbprb_checker.sv
// ----------------------------------------------------------------------------
// VRB to PRB interleaver checker
// Port-level properties of the core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module vrbprb_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [vrbprb_pkg::PrbW-1:0] prb_index_o,
  input logic                      out_of_range_o
);
  import vrbprb_pkg::*;

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(prb_index_o) && $stable(out_of_range_o))
    else $error("stalled result changed");

  // The input side backs up only when a result is waiting and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output can drain");

  // An out-of-range result carries a zero index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> prb_index_o == '0)
    else $error("out-of-range result with nonzero index");

  // An accepted request reaches the output when the receiver takes results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted request did not produce a result");

endmodule

bind vrb_to_prb_interleaver_core vrbprb_checker u_vrbprb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .prb_index_o    (prb_index_o),
  .out_of_range_o (out_of_range_o)
);

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// VRB to PRB interleaver testbench
// Drives VRB index requests through the core under a series of mapping
// configurations and compares every result with an in-bench prediction.
// ----------------------------------------------------------------------------
module tb;
  import vrbprb_pkg::*;

  localparam int unsigned TimeoutCycles = 200000;
  localparam int unsigned HoldCycles    = 48;
  localparam int unsigned SettleCycles  = 4;
  localparam logic [2:0]  ModeUnusedHi  = 3'd7;

  typedef struct packed {
    logic [PrbW-1:0] prb;
    logic            oor;
  } prb_result_t;

  typedef enum int unsigned {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_style_e;

  class prb_scoreboard;
    logic [2:0]          map_mode;
    logic [CfgDataW-1:0] cset_base;
    logic [CfgDataW-1:0] bwp_start;
    logic [CfgDataW-1:0] bwp_len;
    logic [1:0]          bundle_lg;
    logic [CfgDataW-1:0] list_len;
    prb_result_t         prb_expected[$];
    int unsigned         mismatches;

    function new();
      map_mode      = MODE_NONIL_OTHER;
      cset_base     = '0;
      bwp_start     = '0;
      bwp_len       = 9'd275;
      bundle_lg     = 2'd1;
      list_len      = 9'd275;
      mismatches    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_MAP_MODE:      map_mode      = val[2:0];
        CFG_CSET_BASE:     cset_base     = val;
        CFG_BWP_START:     bwp_start     = val;
        CFG_BWP_LEN:       bwp_len       = val;
        CFG_BUNDLE_LOG2:   bundle_lg     = val[1:0];
        CFG_LIST_LENGTH:   list_len      = val;
        default: ;
      endcase
    endfunction

    // Predicts the mapping of one accepted request. All arithmetic is 32 bits
    // wide so that inconsistent geometry wraps the same way as the hardware.
    function void note_request(logic [VrbW-1:0] vrb);
      bit [31:0]   v, len, ofs, l, first, last, nb, t, s, bs, cs, d, j, k, cols, f, prb;
      bit          il;
      prb_result_t r;
      v   = vrb;
      s   = bwp_len;
      bs  = bwp_start;
      cs  = cset_base;
      len = (list_len < MaxBlocksDef) ? list_len : MaxBlocksDef;
      ofs = 0;
      l = 2;
      first = 0;
      last = 0;
      nb = 0;
      il = 1'b1;
      if (v >= len) begin
        r.prb = '0;
        r.oor = 1'b1;
      end else begin
        case (map_mode)
          MODE_NONIL_COMMON: begin
            ofs = cs;
            il  = 1'b0;
          end
          MODE_IL_CORESET0: begin
            ofs   = cs;
            nb    = (s + 1) / 2;
            first = 2;
            last  = (s % 2 != 0) ? s % 2 : 2;
          end
          MODE_IL_COMMON: begin
            ofs   = cs;
            t     = s + cs + bs;
            nb    = (t + 1) / 2;
            first = 2 - ((bs + cs) % 2);
            last  = (t % 2 != 0) ? t % 2 : 2;
          end
          MODE_IL_OTHER: begin
            l     = 32'd1 << bundle_lg;
            t     = s + bs;
            nb    = (t + l - 1) / l;
            first = l - (bs % l);
            last  = (t % l != 0) ? t % l : l;
          end
          default: il = 1'b0;
        endcase
        // First and last bundles stay in place; middle bundles are interleaved.
        if (!il || v < first || v + last >= len) begin
          prb = v + ofs;
        end else begin
          d    = v - first;
          j    = d / l + 1;
          k    = d % l;
          cols = nb / 2;
          f    = (j % 2) * cols + j / 2;
          prb  = (f - 1) * l + first + k + ofs;
        end
        r.prb = prb[PrbW-1:0];
        r.oor = 1'b0;
      end
      prb_expected.push_back(r);
    endfunction

    function void check_result(logic [PrbW-1:0] prb, logic oor);
      prb_result_t want;
      if (prb_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: prb_index %0d out_of_range %0b", prb, oor);
        return;
      end
      want = prb_expected.pop_front();
      if (prb !== want.prb || oor !== want.oor) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: prb_index exp %0d got %0d, out_of_range exp %0b got %0b",
                   want.prb, prb, want.oor, oor);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [VrbW-1:0]     vrb_index_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PrbW-1:0]     prb_index_o;
  logic                out_of_range_o;

  prb_scoreboard sb = new();
  bit            hold_off_req;
  int unsigned   cycle_count;

  vrb_to_prb_interleaver_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .vrb_index_i    (vrb_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .prb_index_o    (prb_index_o),
    .out_of_range_o (out_of_range_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(prb_index_o, out_of_range_o);
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < TimeoutCycles) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Receiver back-pressure: picks a new random style for each span of stall
  // decisions and takes a long hold-off when the stimulus asks for one.
  initial begin : rx_stall_gen
    rx_style_e   style;
    int unsigned span;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      style = rx_style_e'($urandom_range(0, 3));
      span  = $urandom_range(8, 64);
      repeat (span) begin
        if (hold_off_req) begin
          out_stall_i <= 1'b1;
          repeat (HoldCycles) @(posedge clk_i);
          hold_off_req = 1'b0;
        end
        case (style)
          RX_FREE:   out_stall_i <= 1'b0;
          RX_LIGHT:  out_stall_i <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:  out_stall_i <= ($urandom_range(0, 3) != 0);
          default:   out_stall_i <= ~out_stall_i;
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic send_vrb(input logic [VrbW-1:0] v);
    in_valid_i  <= 1'b1;
    vrb_index_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(v);
  endtask

  task automatic sender_gap(input int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.prb_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Waits until the core is empty, writes every register and lets the
  // geometry register pick up the new values.
  task automatic apply_cfg(input logic [2:0] mode, input logic [CfgDataW-1:0] cs,
                           input logic [CfgDataW-1:0] bs, input logic [CfgDataW-1:0] sz,
                           input logic [1:0] lg, input logic [CfgDataW-1:0] ln);
    drain();
    write_reg(CFG_MAP_MODE, {6'd0, mode});
    write_reg(CFG_CSET_BASE, cs);
    write_reg(CFG_BWP_START, bs);
    write_reg(CFG_BWP_LEN, sz);
    write_reg(CFG_BUNDLE_LOG2, {7'd0, lg});
    write_reg(CFG_LIST_LENGTH, ln);
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count, input bit with_gaps);
    int unsigned     burst;
    int unsigned     lim;
    logic [VrbW-1:0] v;
    burst = $urandom_range(1, 16);
    lim   = (sb.list_len < MaxBlocksDef) ? sb.list_len : MaxBlocksDef;
    repeat (count) begin
      if (lim == 0 || $urandom_range(0, 5) == 0) v = VrbW'($urandom_range(0, 511));
      else v = VrbW'($urandom_range(0, lim - 1));
      send_vrb(v);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        if (with_gaps) sender_gap($urandom_range(1, 5));
      end
    end
  endtask

  initial begin : stimulus
    logic [VrbW-1:0]     vrb_q[$];
    logic [2:0]          mode;
    logic [CfgDataW-1:0] cs, bs, sz, ln;
    logic [1:0]          lg;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_MAP_MODE;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    vrb_index_i <= '0;
    hold_off_req = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset configuration: identity mapping over 275 blocks.
    vrb_q = '{9'd0, 9'd274, 9'd275, 9'd511, 9'd170};
    foreach (vrb_q[i]) send_vrb(vrb_q[i]);

    apply_cfg(MODE_IL_CORESET0, 9'd274, 9'd0, 9'd275, 2'd1, 9'd275);
    vrb_q = '{9'd1, 9'd2, 9'd137, 9'd274};
    foreach (vrb_q[i]) send_vrb(vrb_q[i]);

    // Odd BWP plus control set start gives a one-block first bundle.
    apply_cfg(MODE_IL_COMMON, 9'd3, 9'd4, 9'd20, 2'd1, 9'd20);
    vrb_q = '{9'd0, 9'd1, 9'd18, 9'd19};
    foreach (vrb_q[i]) send_vrb(vrb_q[i]);

    apply_cfg(MODE_IL_OTHER, 9'd0, 9'd5, 9'd30, 2'd2, 9'd30);
    vrb_q = '{9'd2, 9'd3, 9'd26, 9'd27};
    foreach (vrb_q[i]) send_vrb(vrb_q[i]);

    // Bundle size code 3 is used as eight blocks.
    apply_cfg(MODE_IL_OTHER, 9'd0, 9'd3, 9'd40, 2'd3, 9'd40);
    send_vrb(9'd4);
    send_vrb(9'd20);

    // Single-block bundles where the first and last bundle coincide.
    apply_cfg(MODE_IL_OTHER, 9'd0, 9'd0, 9'd1, 2'd0, 9'd1);
    send_vrb(9'd0);

    // An unused mode code behaves as plain identity without offset.
    apply_cfg(ModeUnusedHi, 9'd100, 9'd100, 9'd275, 2'd1, 9'd275);
    send_vrb(9'd100);
    send_vrb(9'd300);

    apply_cfg(MODE_NONIL_COMMON, 9'd274, 9'd0, 9'd275, 2'd1, 9'd275);
    send_vrb(9'd274);

    // An empty list flags every request as out of range.
    apply_cfg(MODE_NONIL_COMMON, 9'd0, 9'd0, 9'd275, 2'd1, 9'd0);
    send_vrb(9'd0);

    for (int p = 0; p < 16; p++) begin
      if (p == 0) begin
        mode = MODE_IL_OTHER; cs = 9'd511; bs = 9'd511; sz = 9'd511; lg = 2'd3; ln = 9'd511;
      end else if (p == 1) begin
        mode = MODE_IL_COMMON; cs = 9'd274; bs = 9'd274; sz = 9'd275; lg = 2'd2; ln = 9'd275;
      end else if (p == 2) begin
        mode = MODE_IL_CORESET0; cs = 9'd0; bs = 9'd0; sz = 9'd0; lg = 2'd0; ln = 9'd0;
      end else begin
        mode = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
        sz   = ($urandom_range(0, 2) == 0) ? CfgDataW'($urandom_range(1, 12))
                                           : CfgDataW'($urandom_range(1, 275));
        cs   = CfgDataW'($urandom_range(0, 274));
        bs   = CfgDataW'($urandom_range(0, 274));
        lg   = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 1) * 3)
                                           : 2'($urandom_range(1, 2));
        ln   = ($urandom_range(0, 4) == 0) ? CfgDataW'($urandom_range(0, 511)) : sz;
      end
      apply_cfg(mode, cs, bs, sz, lg, ln);
      // A long receiver hold-off while requests keep coming back to back.
      if (p == 4 || p == 10) begin
        hold_off_req = 1'b1;
        send_random(24, 1'b0);
      end
      send_random(48, (p % 3) != 0);
    end

    drain();
    if (sb.mismatches == 0 && sb.prb_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/vrbprb_pkg.sv
hdl/vrb_to_prb_interleaver_core.sv
hdl/vrbprb_checker.sv
sim/tb.sv
